// ===== sv/twdu_pkg.sv =====
// Package for the text word decrypt and unpack unit: codes, constants and shared types.
`timescale 1ns / 1ps
package twdu_pkg;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_PLAIN  = 2'd1;
  localparam logic [1:0] MODE_PACKED = 2'd2;

  localparam logic [15:0] PACK_MARK = 16'hF100;
  localparam logic [15:0] END_WORD  = 16'hFFFF;
  localparam logic [8:0]  END_CODE  = 9'h1FF;

  localparam logic [15:0] KEY_BASE_RESET = 16'd7123;
  localparam logic [15:0] KEY_STEP_RESET = 16'd18749;

  localparam logic REG_KEY_BASE = 1'b0;
  localparam logic REG_KEY_STEP = 1'b1;

  typedef struct packed {
    logic [15:0] key;
    logic [1:0]  mode;
    logic [23:0] cache;
    logic [4:0]  held;
    logic        first_seen;
  } dec_state_t;

  typedef struct packed {
    logic [15:0] ch;
    logic        eos;
    logic        pk;
    logic        last;
  } result_t;

endpackage

// ===== sv/twdu_decode.sv =====
// Decode logic for one item: key update, plain or packed decoding, up to two results.
`timescale 1ns / 1ps
module twdu_decode
  import twdu_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [15:0] word,
  input  logic        start,
  input  logic [15:0] seed,
  input  logic [15:0] key_step,
  output dec_state_t  nxt,
  output result_t     res0,
  output result_t     res1,
  output logic [1:0]  count
);

  dec_state_t  base;
  logic [15:0] d;
  logic [23:0] c0;
  logic [23:0] c1;
  logic [23:0] c2;
  logic [4:0]  h0;
  logic [4:0]  h1;
  logic [4:0]  h2;
  logic [8:0]  code0;
  logic [8:0]  code1;

  always_comb begin
    base = cur;
    if (start) begin
      base.key        = seed;
      base.mode       = MODE_PLAIN;
      base.first_seen = 1'b0;
      base.cache      = 24'd0;
      base.held       = 5'd0;
    end

    d     = word ^ base.key;
    c0    = base.cache | ({9'd0, d[14:0]} << base.held[3:0]);
    h0    = base.held + 5'd15;
    code0 = c0[8:0];
    c1    = c0 >> 9;
    h1    = h0 - 5'd9;
    code1 = c1[8:0];
    c2    = c1 >> 9;
    h2    = h1 - 5'd9;

    nxt   = base;
    res0  = '0;
    res1  = '0;
    count = 2'd0;

    if (base.mode != MODE_IDLE) begin
      nxt.key = base.key + key_step;
      if (!base.first_seen) begin
        nxt.first_seen = 1'b1;
        nxt.mode       = (d == PACK_MARK) ? MODE_PACKED : MODE_PLAIN;
      end

      if (!base.first_seen && d == PACK_MARK) begin
        count = 2'd0;
      end else if (nxt.mode == MODE_PLAIN || d == END_WORD) begin
        res0.ch   = d;
        res0.eos  = (d == END_WORD);
        res0.pk   = (nxt.mode == MODE_PACKED);
        res0.last = 1'b1;
        count     = 2'd1;
        if (d == END_WORD) begin
          nxt.mode  = MODE_IDLE;
          nxt.cache = 24'd0;
          nxt.held  = 5'd0;
        end
      end else begin
        // Packed word: the cache holds 0, 3 or 6 bits, so one or two codes leave.
        res0.pk = 1'b1;
        res1.pk = 1'b1;
        if (code0 == END_CODE) begin
          res0.ch   = END_WORD;
          res0.eos  = 1'b1;
          res0.last = 1'b1;
          count     = 2'd1;
          nxt.mode  = MODE_IDLE;
          nxt.cache = 24'd0;
          nxt.held  = 5'd0;
        end else if (h1 >= 5'd9) begin
          res0.ch   = {7'd0, code0};
          res1.last = 1'b1;
          count     = 2'd2;
          if (code1 == END_CODE) begin
            res1.ch   = END_WORD;
            res1.eos  = 1'b1;
            nxt.mode  = MODE_IDLE;
            nxt.cache = 24'd0;
            nxt.held  = 5'd0;
          end else begin
            res1.ch   = {7'd0, code1};
            nxt.cache = c2;
            nxt.held  = h2;
          end
        end else begin
          res0.ch   = {7'd0, code0};
          res0.last = 1'b1;
          count     = 2'd1;
          nxt.cache = c1;
          nxt.held  = h1;
        end
      end
    end
  end

endmodule

// ===== sv/text_word_decrypt_unpack_unit.sv =====
// Top level of the text word decrypt and unpack unit: input stage, decode, result buffer.
// The first result of an item passes the input register, then the result buffer.
// Throughput: one item per cycle while each item gives at most one result and every
// result is taken at once; a two-result item holds the single output until both leave.
// The seed multiply sits before the input register, the decode after it.
// Reset (rst, synchronous) zeroes the key and decode state, empties both stages, and
// loads the configuration registers with their defaults.
`timescale 1ns / 1ps
module text_word_decrypt_unpack_unit
  import twdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] word,
  input  logic [15:0] string_index,
  input  logic        start_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] character,
  output logic        end_of_string,
  output logic        packed_res,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] key_base;
  logic [15:0] key_step;

  logic        stage_valid;
  logic [15:0] stage_word;
  logic        stage_start;
  logic [15:0] stage_seed;
  logic [15:0] seed_next;

  dec_state_t  state;
  dec_state_t  state_next;
  result_t     dec_res0;
  result_t     dec_res1;
  logic [1:0]  dec_count;

  result_t     buf0;
  result_t     buf1;
  logic [1:0]  buf_count;

  logic        pop;
  logic        fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_base <= KEY_BASE_RESET;
      key_step <= KEY_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_BASE: key_base <= cfg_wdata;
        REG_KEY_STEP: key_step <= cfg_wdata;
        default:      key_step <= key_step;
      endcase
    end
  end

  // Only the low 16 bits of the product are kept, so they need only the low bits of index + 1.
  assign seed_next = key_base * (string_index + 16'd1);

  assign pop      = out_valid && out_ready;
  assign fire     = stage_valid && (buf_count == 2'd0 || (buf_count == 2'd1 && pop));
  assign in_ready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_word  <= word;
      stage_start <= start_req;
      stage_seed  <= seed_next;
    end
  end

  twdu_decode u_decode (
    .cur      (state),
    .word     (stage_word),
    .start    (stage_start),
    .seed     (stage_seed),
    .key_step (key_step),
    .nxt      (state_next),
    .res0     (dec_res0),
    .res1     (dec_res1),
    .count    (dec_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // On fire the buffer holds just the new item's results (none, one or two).
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= 2'd0;
    end else if (fire) begin
      buf_count <= dec_count;
    end else if (pop) begin
      buf_count <= buf_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      buf0 <= dec_res0;
      buf1 <= dec_res1;
    end else if (pop) begin
      buf0 <= buf1;
    end
  end

  assign out_valid     = (buf_count != 2'd0);
  assign character     = buf0.ch;
  assign end_of_string = buf0.eos;
  assign packed_res    = buf0.pk;
  assign last          = buf0.last;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) buf_count != 2'd3)
    else $error("result buffer count out of range");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (pop && !last) |=> (out_valid && last))
    else $error("second result of an item missing");

  a_eos_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_string) |-> (character == END_WORD && last))
    else $error("terminator result malformed");

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    (fire && state.mode == MODE_IDLE && !stage_start) |-> (dec_count == 2'd0))
    else $error("result produced after end of string");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the text word decrypt and unpack unit.
`timescale 1ns / 1ps
module testbench;
  import twdu_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] idx;
    logic        st;
    logic        raw;
  } text_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] word = 16'd0;
  logic [15:0] string_index = 16'd0;
  logic        start_req = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] character;
  logic        end_of_string;
  logic        packed_res;
  logic        last;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_KEY_BASE;
  logic [15:0] cfg_wdata = 16'd0;

  text_word_decrypt_unpack_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .word(word), .string_index(string_index), .start_req(start_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .character(character), .end_of_string(end_of_string),
    .packed_res(packed_res), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Decoder state as the block should hold it.
  logic [15:0] base_reg = KEY_BASE_RESET;
  logic [15:0] step_reg = KEY_STEP_RESET;
  logic [15:0] dk_key = 16'd0;
  logic [1:0]  dk_mode = MODE_IDLE;
  logic [23:0] dk_cache = 24'd0;
  logic [4:0]  dk_held = 5'd0;
  logic        dk_first = 1'b0;

  text_item_t  words_pending[$];
  result_t     chars_due[$];
  logic [8:0]  code_q[$];

  int n_items = 0;
  int n_results = 0;
  int n_err = 0;
  int cyc = 0;

  function automatic logic [15:0] seed_key(input logic [15:0] idx);
    logic [32:0] p;
    p = base_reg * ({1'b0, idx} + 17'd1);
    return p[15:0];
  endfunction

  function automatic void decode_word(input logic [15:0] w, input logic [15:0] idx,
                                      input logic st);
    logic [15:0] d;
    logic [8:0]  code;
    result_t     r;
    int          n;
    n = 0;
    if (st) begin
      dk_key = seed_key(idx);
      dk_mode = MODE_PLAIN;
      dk_first = 1'b0;
      dk_cache = 24'd0;
      dk_held = 5'd0;
    end
    if (dk_mode == MODE_IDLE) return;
    d = w ^ dk_key;
    dk_key = dk_key + step_reg;
    if (!dk_first) begin
      dk_first = 1'b1;
      if (d == PACK_MARK) begin
        dk_mode = MODE_PACKED;
        return;
      end
      dk_mode = MODE_PLAIN;
    end
    if (dk_mode == MODE_PLAIN || d == END_WORD) begin
      r.ch = d;
      r.eos = (d == END_WORD);
      r.pk = (dk_mode == MODE_PACKED);
      r.last = 1'b1;
      chars_due.insert(chars_due.size(), r);
      if (r.eos) begin
        dk_mode = MODE_IDLE;
        dk_cache = 24'd0;
        dk_held = 5'd0;
      end
      return;
    end
    // Packed text: 15 fresh bits go above the held ones, codes leave from the bottom.
    dk_cache = dk_cache | ({9'd0, d[14:0]} << dk_held[3:0]);
    dk_held = dk_held + 5'd15;
    do begin
      code = dk_cache[8:0];
      dk_held = dk_held - 5'd9;
      dk_cache = dk_cache >> 9;
      r.pk = 1'b1;
      r.last = 1'b0;
      if (code == END_CODE) begin
        r.ch = END_WORD;
        r.eos = 1'b1;
        chars_due.insert(chars_due.size(), r);
        n++;
        dk_mode = MODE_IDLE;
        dk_cache = 24'd0;
        dk_held = 5'd0;
        break;
      end
      r.ch = {7'd0, code};
      r.eos = 1'b0;
      chars_due.insert(chars_due.size(), r);
      n++;
    end while (dk_held >= 5'd9 && n < 2);
    r = chars_due.pop_back();
    r.last = 1'b1;
    chars_due.insert(chars_due.size(), r);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Sender: words are encrypted when they reach the bus, with the key that
  // the decoder will hold once every earlier item has been taken.
  int tx_gap = 0;
  int tx_calm = 0;
  always @(posedge clk) begin : drive_p
    text_item_t  it;
    logic [15:0] key_now;
    logic        hold;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        decode_word(word, string_index, start_req);
        if (tx_calm > 0) begin
          tx_calm--;
        end else begin
          tx_gap = idle_len();
          if ($urandom_range(0, 99) < 3) tx_calm = $urandom_range(40, 120);
        end
      end
      if (!hold) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (words_pending.size() > 0) begin
          it = words_pending.pop_front();
          key_now = it.st ? seed_key(it.idx) : dk_key;
          word <= it.raw ? it.w : (it.w ^ key_now);
          string_index <= it.idx;
          start_req <= it.st;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, calm stretches, and now and then a long hold-off.
  int rx_stall = 0;
  int rx_calm = 0;
  int hold_next = 100;
  always @(posedge clk) begin : watch_p
    result_t got;
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {character, end_of_string, packed_res, last};
        n_results++;
        if (chars_due.size() == 0) begin
          n_err++;
          if (n_err <= 40)
            $display("%0t: unexpected item ch=%h eos=%b pk=%b last=%b", $time,
                     got.ch, got.eos, got.pk, got.last);
        end else begin
          want = chars_due.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= 40)
              $display("%0t: expected ch=%h eos=%b pk=%b last=%b, got ch=%h eos=%b pk=%b last=%b",
                       $time, want.ch, want.eos, want.pk, want.last,
                       got.ch, got.eos, got.pk, got.last);
          end
        end
        if (rx_calm > 0) begin
          rx_calm--;
        end else begin
          rx_stall = idle_len();
          if ($urandom_range(0, 99) < 3) rx_calm = $urandom_range(40, 120);
        end
        if (n_results >= hold_next) begin
          rx_stall = 300;
          hold_next += 600;
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc == LIMIT) begin
      $display("text_word_decrypt_unpack_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_item(input logic [15:0] w, input logic [15:0] idx, input logic st,
                            input logic raw);
    text_item_t it;
    it.w = w;
    it.idx = idx;
    it.st = st;
    it.raw = raw;
    words_pending.insert(words_pending.size(), it);
    if (st || !raw) n_items++;
  endtask

  task automatic put_packed(input logic [14:0] bits);
    logic top;
    top = 1'($urandom_range(0, 1));
    // All ones would decrypt to the terminator word.
    if (bits == 15'h7FFF) top = 1'b0;
    queue_item({top, bits}, 16'($urandom), 1'b0, 1'b0);
  endtask

  // Packs the codes waiting in code_q into 15-bit words behind a pack marker.
  task automatic send_packed(input logic [15:0] idx, input bit with_end);
    logic [31:0] acc;
    int          nb;
    acc = 32'd0;
    nb = 0;
    queue_item(PACK_MARK, idx, 1'b1, 1'b0);
    if (with_end) code_q.insert(code_q.size(), END_CODE);
    while (code_q.size() > 0) begin
      acc = acc | ({23'd0, code_q.pop_front()} << nb);
      nb += 9;
      if (nb >= 15) begin
        put_packed(acc[14:0]);
        acc = acc >> 15;
        nb -= 15;
      end
    end
    if (nb > 0) begin
      acc = acc | ($urandom << nb);
      put_packed(acc[14:0]);
    end
  endtask

  function automatic logic [15:0] rand_char();
    logic [15:0] c;
    case ($urandom_range(0, 19))
      0: c = 16'h0000;
      1: c = 16'hFFFE;
      2: c = PACK_MARK;
      3: c = {7'd0, END_CODE};
      default: c = 16'($urandom);
    endcase
    if (c == END_WORD) c = 16'hFFFE;
    return c;
  endfunction

  function automatic logic [8:0] rand_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 9'h000;
    if (r < 16) return END_CODE - 9'd1;
    return 9'($urandom_range(0, 510));
  endfunction

  task automatic send_plain(input logic [15:0] idx, input int len, input bit with_end);
    logic [15:0] c;
    if (len == 0) begin
      queue_item(END_WORD, idx, 1'b1, 1'b0);
      return;
    end
    c = rand_char();
    if (c == PACK_MARK) c = 16'h0041;
    queue_item(c, idx, 1'b1, 1'b0);
    repeat (len - 1) queue_item(rand_char(), 16'($urandom), 1'b0, 1'b0);
    if (with_end) queue_item(END_WORD, 16'($urandom), 1'b0, 1'b0);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (words_pending.size() != 0 || in_valid || chars_due.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic i, input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_wdata <= v;
    if (i == REG_KEY_BASE) base_reg = v;
    else step_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stim_p
    logic [15:0] bases[4];
    logic [15:0] steps[4];
    int          target;
    int          sel;
    bases = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001};
    steps = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000};
    bases[2] = 16'($urandom);
    steps[2] = 16'($urandom);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, registers at their reset values.
    queue_item(16'h1234, 16'h0007, 1'b0, 1'b1);
    queue_item(16'h0000, 16'h0000, 1'b1, 1'b0);
    queue_item(16'hFFFE, 16'h0000, 1'b0, 1'b0);
    queue_item(PACK_MARK, 16'h0000, 1'b0, 1'b0);
    queue_item({7'd0, END_CODE}, 16'h0000, 1'b0, 1'b0);
    queue_item(END_WORD, 16'h0000, 1'b0, 1'b0);
    queue_item(16'hBEEF, 16'hFFFF, 1'b0, 1'b1);
    // Terminator as the very first word, largest index.
    queue_item(END_WORD, 16'hFFFF, 1'b1, 1'b0);
    code_q = '{9'h000, 9'h1FE, 9'h0AB, 9'h155};
    send_packed(16'd5, 1'b1);
    // Terminator word inside packed text.
    queue_item(PACK_MARK, 16'd2, 1'b1, 1'b0);
    queue_item(END_WORD, 16'd0, 1'b0, 1'b0);
    // Restarts in the middle of a plain and of a packed string.
    queue_item(16'h0041, 16'd3, 1'b1, 1'b0);
    queue_item(16'h0042, 16'd0, 1'b0, 1'b0);
    queue_item(PACK_MARK, 16'd4, 1'b1, 1'b0);
    queue_item(16'hC123, 16'd0, 1'b0, 1'b0);
    queue_item(END_WORD, 16'hFFFE, 1'b1, 1'b0);
    // The terminator code comes first of two codes in one word; the second is dropped.
    code_q = '{9'h011, END_CODE, 9'h0CC};
    send_packed(16'd9, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_KEY_BASE, bases[ph]);
      write_reg(REG_KEY_STEP, steps[ph]);
      @(negedge clk);
      target = n_items + 270;
      while (n_items < target) begin
        sel = $urandom_range(0, 99);
        if (sel < 42) begin
          send_plain(16'($urandom), $urandom_range(0, 12), 1'b1);
        end else if (sel < 80) begin
          repeat ($urandom_range(0, 14)) code_q.insert(code_q.size(), rand_code());
          send_packed(16'($urandom), 1'b1);
        end else if (sel < 90) begin
          // Strings cut short by the next start, or ended by a terminator word.
          if ($urandom_range(0, 1)) begin
            send_plain(16'($urandom), $urandom_range(1, 6), 1'b0);
          end else begin
            repeat ($urandom_range(1, 8)) code_q.insert(code_q.size(), rand_code());
            send_packed(16'($urandom), 1'b0);
            if ($urandom_range(0, 1)) queue_item(END_WORD, 16'($urandom), 1'b0, 1'b0);
          end
        end else begin
          repeat ($urandom_range(1, 4))
            queue_item(16'($urandom), 16'($urandom), 1'b0, 1'b1);
          if ($urandom_range(0, 1)) queue_item(16'($urandom), 16'($urandom), 1'b1, 1'b1);
        end
      end
      wait_drained();
    end

    if (n_err == 0) begin
      $display("text_word_decrypt_unpack_unit: match");
    end else begin
      $display("text_word_decrypt_unpack_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/twdu_pkg.sv
sv/twdu_decode.sv
sv/text_word_decrypt_unpack_unit.sv
tb/sv/testbench.sv
